FILE: rtl/lbw_pkg.sv
// shared types and constants of the limbus edge window detector
package lbw_pkg;

  localparam int WINDOW_DEF     = 30;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int PIX_W = 8;

  localparam int MASK_NUM = 577;
  localparam int MASK_DEN = 1000;

  localparam logic [11:0] IMAGE_WIDTH_RST = 12'd640;
  localparam logic [10:0] PUPIL_X_RST     = 11'd320;
  localparam logic [10:0] PUPIL_Y_RST     = 11'd240;
  localparam logic [7:0]  NEAR_LIMIT_RST  = 8'd20;
  localparam logic [7:0]  FAR_LIMIT_RST   = 8'd35;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH = 3'd0,
    REG_PUPIL_X     = 3'd1,
    REG_PUPIL_Y     = 3'd2,
    REG_NEAR_LIMIT  = 3'd3,
    REG_FAR_LIMIT   = 3'd4
  } lbw_reg_t;

  typedef struct packed {
    logic valid;
    logic has_res;
    logic interior;
  } lbw_ctl_t;

endpackage

FILE: rtl/lbw_cell.sv
// one pixel cell of the row window shift chain
module lbw_cell
  import lbw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic [PIX_W-1:0] pix_in,
  output logic [PIX_W-1:0] pix_out
);

  logic [PIX_W-1:0] pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix <= '0;
    end else if (shift) begin
      pix <= pix_in;
    end
  end

  assign pix_out = pix;

endmodule

FILE: rtl/lbw_eval.sv
// mean tests and angular mask, registered into stage s2
module lbw_eval
  import lbw_pkg::*;
#(
  parameter int WINDOW     = WINDOW_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  lbw_ctl_t                          s1_ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0]      s1_col,
  input  logic [$clog2(MAX_HEIGHT)-1:0]     s1_row,
  input  logic [$clog2(WINDOW)-1:0]         s1_flush,
  input  logic [PIX_W-1:0]                  center,
  input  logic [$clog2(WINDOW*255+1)-1:0]   ahead,
  input  logic [$clog2(WINDOW*255+1)-1:0]   behind,
  input  logic [10:0]                       pupil_x,
  input  logic [10:0]                       pupil_y,
  input  logic [7:0]                        near_limit,
  input  logic [7:0]                        far_limit,
  output lbw_ctl_t                          s2_ctl,
  output logic [$clog2(WINDOW)-1:0]         s2_flush,
  output logic                              edge_hit
);

  localparam int SW  = $clog2(WINDOW*255+1);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int FW  = $clog2(WINDOW);
  localparam int XW  = (CW > 11) ? CW : 11;
  localparam int YW  = (RW > 11) ? RW : 11;
  localparam int DYW = YW + 1;
  localparam int SMW = ((DYW > XW + 1) ? DYW : XW + 1) + 1;
  localparam int MW  = SMW + 11;

  logic [SW-1:0]         wv;
  logic signed [SW:0]    da;
  logic signed [SW:0]    db;
  logic [SW-1:0]         da_abs;
  logic [SW-1:0]         db_abs;
  logic                  left;
  logic [XW-1:0]         col_x;
  logic [XW-1:0]         px_x;
  logic [XW-1:0]         d;
  logic signed [DYW-1:0] dy;
  logic signed [SMW-1:0] dy_plus_d;
  logic                  mask_lo;

  logic [SW-1:0]         inner;
  logic [SW-1:0]         outer;
  logic signed [DYW-1:0] dy_q;
  logic [XW-1:0]         d_q;

  logic [SW-1:0]         near_scaled;
  logic [SW-1:0]         far_scaled;
  logic signed [MW-1:0]  lhs;
  logic signed [MW-1:0]  rhs;

  always_comb begin
    wv      = SW'(WINDOW * int'(center));
    da      = $signed({1'b0, ahead}) - $signed({1'b0, wv});
    db      = $signed({1'b0, behind}) - $signed({1'b0, wv});
    da_abs  = da[SW] ? SW'(-da) : SW'(da);
    db_abs  = db[SW] ? SW'(-db) : SW'(db);
    col_x   = XW'(s1_col);
    px_x    = XW'(pupil_x);
    left    = col_x < px_x;
    d       = left ? (px_x - col_x) : (col_x - px_x);
    dy      = $signed({1'b0, YW'(pupil_y)}) - $signed({1'b0, YW'(s1_row)});
    dy_plus_d = SMW'(dy) + $signed(SMW'({1'b0, d}));
    mask_lo = dy_plus_d < 0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (load) begin
      s2_ctl.valid    <= s1_ctl.valid;
      s2_ctl.has_res  <= s1_ctl.has_res;
      s2_ctl.interior <= s1_ctl.interior && !mask_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_flush <= s1_flush;
      inner    <= left ? da_abs : db_abs;
      outer    <= left ? db_abs : da_abs;
      dy_q     <= dy;
      d_q      <= d;
    end
  end

  always_comb begin
    near_scaled = SW'(int'(near_limit) * WINDOW);
    far_scaled  = SW'(int'(far_limit) * WINDOW);
    lhs         = MW'(dy_q) * MW'(MASK_DEN);
    rhs         = $signed(MW'({1'b0, d_q})) * MW'(MASK_NUM);
    edge_hit    = s2_ctl.interior && (inner < near_scaled) && (outer > far_scaled)
                  && !(lhs > rhs);
  end

endmodule

FILE: rtl/limbus_edge_window_detector_top.sv
// top level of the limbus edge window detector
//
//   port group   handshake            carries
//   pixel in     pix_valid/pix_stall  pixel, frame_start
//   result out   res_valid/res_stall  edge_res, row_end
//   register     cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one pixel per cycle while pix_stall is low; a result is registered in s1, s2 and the output
// register after the pixel that causes it; the last pixel of a row adds up to WINDOW-1 zero beats
// from the output stage, during which the pixel channel stalls once the two inner stages are full
// rst clears the window cells, sums, counters and stage valids
// the output register lets a new pixel in while a result still waits
module limbus_edge_window_detector_top
  import lbw_pkg::*;
#(
  parameter int WINDOW     = WINDOW_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             pix_valid,
  output logic             pix_stall,
  input  logic [PIX_W-1:0] pixel,
  input  logic             frame_start,
  output logic             res_valid,
  input  logic             res_stall,
  output logic             edge_res,
  output logic             row_end,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [11:0]      cfg_data
);

  localparam int DEPTH = 2 * WINDOW - 1;
  localparam int SW    = $clog2(WINDOW*255+1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int FW    = $clog2(WINDOW);
  localparam int EW    = (CW + 1 > 12) ? CW + 1 : 12;

  logic [11:0] image_width;
  logic [10:0] pupil_x;
  logic [10:0] pupil_y;
  logic [7:0]  near_limit;
  logic [7:0]  far_limit;

  logic [PIX_W-1:0] taps [DEPTH];
  logic [SW-1:0]    ahead;
  logic [SW-1:0]    behind;
  logic [CW-1:0]    column_count;
  logic [RW-1:0]    row_count;

  lbw_ctl_t      s1_ctl;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  logic [FW-1:0] s1_flush;
  lbw_ctl_t      s2_ctl;
  logic [FW-1:0] s2_flush;
  logic          edge_hit;

  logic [FW-1:0] out_rem;

  logic          accept;
  logic          pop;
  logic          out_load;
  logic          s2_adv;
  logic          s1_adv;

  logic [EW-1:0] w_eff;
  logic [EW-1:0] iw_ext;
  logic [EW-1:0] c_ext;
  logic [CW-1:0] c;
  logic [RW-1:0] row;
  logic          last;
  logic          has_res;
  logic          interior;
  logic [FW-1:0] flush;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= IMAGE_WIDTH_RST;
      pupil_x     <= PUPIL_X_RST;
      pupil_y     <= PUPIL_Y_RST;
      near_limit  <= NEAR_LIMIT_RST;
      far_limit   <= FAR_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: image_width <= cfg_data;
        REG_PUPIL_X:     pupil_x     <= cfg_data[10:0];
        REG_PUPIL_Y:     pupil_y     <= cfg_data[10:0];
        REG_NEAR_LIMIT:  near_limit  <= cfg_data[7:0];
        REG_FAR_LIMIT:   far_limit   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // stage flow
  assign pop      = res_valid && !res_stall;
  assign out_load = !res_valid || (pop && (out_rem == '0));
  assign s2_adv   = !s2_ctl.valid || out_load;
  assign s1_adv   = !s1_ctl.valid || s2_adv;
  assign pix_stall = !s1_adv;
  assign accept   = pix_valid && s1_adv;

  // window cell chain
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      lbw_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .shift   (accept),
        .pix_in  (pixel),
        .pix_out (taps[k])
      );
    end else begin : g_body
      lbw_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .shift   (accept),
        .pix_in  (taps[k-1]),
        .pix_out (taps[k])
      );
    end
  end

  // running window sums
  always_ff @(posedge clk) begin
    if (rst) begin
      ahead  <= '0;
      behind <= '0;
    end else if (accept) begin
      ahead  <= ahead + SW'(pixel) - SW'(taps[WINDOW-1]);
      behind <= behind + SW'(taps[WINDOW-2]) - SW'(taps[DEPTH-1]);
    end
  end

  // column and row bookkeeping
  always_comb begin
    iw_ext   = EW'(image_width);
    if (iw_ext == '0) begin
      w_eff = EW'(1);
    end else if (iw_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = iw_ext;
    end
    c        = frame_start ? '0 : column_count;
    row      = frame_start ? '0 : row_count;
    c_ext    = EW'(c);
    last     = (c_ext + EW'(1)) >= w_eff;
    has_res  = c_ext >= EW'(WINDOW - 1);
    interior = (c_ext >= EW'(DEPTH)) && ((c_ext + EW'(2)) <= w_eff);
    if (!last) begin
      flush = '0;
    end else if (c_ext >= EW'(WINDOW - 2)) begin
      flush = FW'(WINDOW - 1);
    end else begin
      flush = FW'(c + CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (last) begin
        column_count <= '0;
        row_count    <= (row == RW'(MAX_HEIGHT - 1)) ? '0 : row + RW'(1);
      end else begin
        column_count <= c + CW'(1);
        row_count    <= row;
      end
    end
  end

  // first stage, evaluated against the window cells
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (s1_adv) begin
      s1_ctl.valid    <= accept && (has_res || last);
      s1_ctl.has_res  <= has_res;
      s1_ctl.interior <= interior;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= c - CW'(WINDOW - 1);
      s1_row   <= row;
      s1_flush <= flush;
    end
  end

  lbw_eval #(
    .WINDOW     (WINDOW),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_eval (
    .clk        (clk),
    .rst        (rst),
    .load       (s2_adv),
    .s1_ctl     (s1_ctl),
    .s1_col     (s1_col),
    .s1_row     (s1_row),
    .s1_flush   (s1_flush),
    .center     (taps[WINDOW-1]),
    .ahead      (ahead),
    .behind     (behind),
    .pupil_x    (pupil_x),
    .pupil_y    (pupil_y),
    .near_limit (near_limit),
    .far_limit  (far_limit),
    .s2_ctl     (s2_ctl),
    .s2_flush   (s2_flush),
    .edge_hit   (edge_hit)
  );

  // output register, then the row end zero beats
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      out_rem   <= '0;
    end else if (out_load) begin
      if (s2_ctl.valid && s2_ctl.has_res) begin
        res_valid <= 1'b1;
        out_rem   <= s2_flush;
      end else if (s2_ctl.valid && (s2_flush != '0)) begin
        res_valid <= 1'b1;
        out_rem   <= s2_flush - FW'(1);
      end else begin
        res_valid <= 1'b0;
        out_rem   <= '0;
      end
    end else if (pop) begin
      out_rem <= out_rem - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (s2_ctl.has_res) begin
        edge_res <= edge_hit;
        row_end  <= 1'b0;
      end else begin
        edge_res <= 1'b0;
        row_end  <= (s2_flush == FW'(1));
      end
    end else if (pop) begin
      edge_res <= 1'b0;
      row_end  <= (out_rem == FW'(1));
    end
  end

endmodule
